@@ design/hls_pkg.sv @@
// ---------------------------------------------------------------------------
// hls_pkg: shared types and constants of the list scheduler
// Item layouts, mode codes, register indexes and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package hls_pkg;

   localparam int MAX_TASKS_DEF = 64;
   localparam int MAX_PROCS_DEF = 8;
   localparam int COST_BITS_DEF = 16;

   localparam int DATA_BITS = 16;
   localparam int RANK_BITS = 40;
   localparam int TIME_BITS = 32;

   localparam logic [RANK_BITS-1:0] RANK_MAX = '1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam logic [2:0] MODE_COST    = 3'd0;
   localparam logic [2:0] MODE_RATE    = 3'd1;
   localparam logic [2:0] MODE_STARTUP = 3'd2;
   localparam logic [2:0] MODE_EDGE    = 3'd3;
   localparam logic [2:0] MODE_START   = 3'd4;

   localparam int CSR_DATA_BITS = 7;
   localparam int CSR_IDX_BITS  = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TASK_COUNT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROC_COUNT = 1'd1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [5:0]  row_index;
      logic [5:0]  col_index;
      logic [15:0] entry_value;
      logic        has_edge;
   } req_type;

   typedef struct packed {
      logic [5:0]  task_id;
      logic [2:0]  chosen_processor;
      logic [31:0] start_time;
      logic [31:0] finish_time;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/heft_list_scheduler_unit.sv @@
// ---------------------------------------------------------------------------
// heft_list_scheduler_unit: earliest-finish-time list scheduler
// Loads cost, rate, startup and edge tables, then schedules a task graph.
// ---------------------------------------------------------------------------
// Usage: the req channel takes load items (cost, rate, startup, edge) at one
// item per cycle; they write the tables and give no result. A start item runs
// the whole schedule: upward ranks, insertion sort by rank, then placement of
// each task. One rsp item comes out per task in scheduling order, last set on
// the final one. req_ready stays low from the start item until the final
// result has been loaded into the output register.
// Schedule phases: ranks, then the sort, then a clear of the placement state,
// and per task a scan for predecessors plus either a pass over the processors
// for an entry task or, for each processor, a scan of the tasks and a division
// of size by rate for each placed predecessor on another processor (the
// 16-step shared divider).
// Reset: task_count 2, proc_count 1, outputs idle; table contents undefined.
// A stalled rsp channel holds the current result and the sequencer waits
// before loading the next one; load items are still accepted while the last
// result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module heft_list_scheduler_unit #(
   parameter int MAX_TASKS = hls_pkg::MAX_TASKS_DEF,
   parameter int MAX_PROCS = hls_pkg::MAX_PROCS_DEF,
   parameter int COST_BITS = hls_pkg::COST_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire hls_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output hls_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [hls_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [hls_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import hls_pkg::*;

   localparam int TW  = $clog2(MAX_TASKS);
   localparam int CW  = TW + 1;
   localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int QW  = PW + 1;
   localparam int SW  = COST_BITS + QW;
   localparam int CD  = MAX_TASKS * MAX_PROCS;
   localparam int RD  = MAX_PROCS * MAX_PROCS;
   localparam int ED  = MAX_TASKS * MAX_TASKS;
   localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
   localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
   localparam int EAW = (ED > 1) ? $clog2(ED) : 1;

   typedef enum logic [5:0] {
      ST_IDLE, RK_CRD, RK_CACC, RK_SINIT, RK_SRD, RK_SACC, RK_WR,
      OR_TRK, OR_TGET, OR_CHK, OR_OGET, OR_RRD, OR_CMP, OR_PUT,
      SC_INIT, SC_ORD, SC_TGET, SC_ERD, SC_EACC, SC_BR, EN_RD, EN_ACC,
      P_INIT, P_ERD, P_EGET, P_RRD, P_RGET, P_DIV, P_ARR, P_NEXT,
      P_CRD, P_CACC, SC_EMIT
   } state_type;

   state_type state_ff;

   logic [6:0]              task_count_ff;
   logic [3:0]              proc_count_ff;
   logic [CW-1:0]           n_ff, i_ff, k_ff, s_ff, pos_ff;
   logic [QW-1:0]           q_ff, j_ff;
   logic [TW-1:0]           t_ff, prev_ff;
   logic [SW-1:0]           cost_sum_ff;
   logic [RANK_BITS:0]      best_ff;
   logic [RANK_BITS-1:0]    rank_t_ff;
   logic                    entry_ff;
   logic [TIME_BITS-1:0]    est_ff, bs_ff, bf_ff, fin_ff;
   logic [PW-1:0]           bp_ff, kp_ff;
   logic [DATA_BITS-1:0]    size_ff, rate_ff, startup_ff, quo_ff;
   logic [DATA_BITS:0]      rem_ff;
   logic [4:0]              div_cnt_ff;
   logic [MAX_TASKS-1:0]    placed_ff;
   logic [TIME_BITS-1:0]    pft_ff [MAX_PROCS];
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   // ram ports
   logic                    cost_we, rate_we, st_we, edge_we;
   logic [CAW-1:0]          cost_waddr, cost_raddr;
   logic [RAW-1:0]          rate_waddr, rate_raddr;
   logic [PW-1:0]           st_waddr, st_raddr;
   logic [EAW-1:0]          edge_waddr, edge_raddr;
   logic [COST_BITS-1:0]    cost_wdata, cost_rdata;
   logic [DATA_BITS-1:0]    rate_rdata, st_rdata;
   logic [DATA_BITS:0]      edge_wdata, edge_rdata;
   logic                    rank_we, order_we, ap_we, tf_we;
   logic [TW-1:0]           rank_waddr, rank_raddr, order_waddr, order_raddr;
   logic [RANK_BITS-1:0]    rank_wdata, rank_rdata;
   logic [TW-1:0]           order_wdata, order_rdata;
   logic [PW-1:0]           ap_rdata;
   logic [TIME_BITS-1:0]    tf_rdata;

   logic                    req_fire, out_free, in_rank, emit_fire;
   logic [TW-1:0]           cost_row, edge_row, edge_col;
   logic [CW-1:0]           n_w;
   logic [QW-1:0]           q_w;
   logic [DATA_BITS+QW-1:0] prod_w;
   logic [RANK_BITS:0]      v_w;
   logic [RANK_BITS+1:0]    rsum_w;
   logic [TIME_BITS:0]      fsum_w, asum_w;
   logic [TIME_BITS-1:0]    fi_w, comm_w, arr_w;
   logic [DATA_BITS:0]      rshift_w;
   logic                    cmp_less, last_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign n_w = (32'(task_count_ff) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count_ff);
   assign q_w = (proc_count_ff == 4'd0) ? QW'(1) :
                ((32'(proc_count_ff) > MAX_PROCS) ? QW'(MAX_PROCS) : QW'(proc_count_ff));

   assign in_rank = (state_ff == RK_CRD) || (state_ff == RK_CACC) ||
                    (state_ff == RK_SRD) || (state_ff == RK_SACC);

   // load writes
   assign cost_we    = req_fire && (req_data.mode == MODE_COST) &&
                       (32'(req_data.row_index) < MAX_TASKS) &&
                       (32'(req_data.col_index) < MAX_PROCS);
   assign rate_we    = req_fire && (req_data.mode == MODE_RATE) &&
                       (32'(req_data.row_index) < MAX_PROCS) &&
                       (32'(req_data.col_index) < MAX_PROCS);
   assign st_we      = req_fire && (req_data.mode == MODE_STARTUP) &&
                       (32'(req_data.row_index) < MAX_PROCS);
   assign edge_we    = req_fire && (req_data.mode == MODE_EDGE) &&
                       (32'(req_data.row_index) < MAX_TASKS) &&
                       (32'(req_data.col_index) < MAX_TASKS);
   assign cost_waddr = CAW'(32'(req_data.row_index) * MAX_PROCS + 32'(req_data.col_index));
   assign rate_waddr = RAW'(32'(req_data.row_index) * MAX_PROCS + 32'(req_data.col_index));
   assign st_waddr   = PW'(req_data.row_index);
   assign edge_waddr = EAW'(32'(req_data.row_index) * MAX_TASKS + 32'(req_data.col_index));
   assign cost_wdata = COST_BITS'(req_data.entry_value);
   assign edge_wdata = {req_data.has_edge, req_data.entry_value};

   // read addresses
   assign cost_row   = in_rank ? i_ff[TW-1:0] : t_ff;
   assign cost_raddr = CAW'(32'(cost_row) * MAX_PROCS + 32'(j_ff[PW-1:0]));
   assign edge_row   = in_rank ? i_ff[TW-1:0] : k_ff[TW-1:0];
   assign edge_col   = in_rank ? k_ff[TW-1:0] : t_ff;
   assign edge_raddr = EAW'(32'(edge_row) * MAX_TASKS + 32'(edge_col));
   assign rate_raddr = RAW'(32'(kp_ff) * MAX_PROCS + 32'(j_ff[PW-1:0]));
   assign st_raddr   = kp_ff;

   always_comb begin
      case (state_ff)
         OR_TRK:  rank_raddr = t_ff;
         OR_RRD:  rank_raddr = prev_ff;
         default: rank_raddr = k_ff[TW-1:0];
      endcase
   end

   assign order_raddr = (state_ff == OR_CHK) ? TW'(pos_ff - 1'b1) : s_ff[TW-1:0];

   // rank arithmetic
   assign prod_w   = {{QW{1'b0}}, edge_rdata[DATA_BITS-1:0]} * {{DATA_BITS{1'b0}}, q_ff};
   assign v_w      = (RANK_BITS+1)'(prod_w) + (RANK_BITS+1)'(rank_rdata);
   assign rsum_w   = (RANK_BITS+2)'(best_ff) + (RANK_BITS+2)'(cost_sum_ff);
   assign rank_we    = (state_ff == RK_WR);
   assign rank_waddr = i_ff[TW-1:0];
   assign rank_wdata = (rsum_w > (RANK_BITS+2)'(RANK_MAX)) ? RANK_MAX : rsum_w[RANK_BITS-1:0];

   // sort writes
   assign cmp_less    = rank_rdata < rank_t_ff;
   assign order_we    = ((state_ff == OR_CMP) && cmp_less) || (state_ff == OR_PUT);
   assign order_waddr = pos_ff[TW-1:0];
   assign order_wdata = (state_ff == OR_PUT) ? t_ff : prev_ff;

   // finish-time arithmetic
   assign fsum_w = (TIME_BITS+1)'(est_ff) + (TIME_BITS+1)'(cost_rdata);
   assign fi_w   = fsum_w[TIME_BITS] ? TIME_MAX : fsum_w[TIME_BITS-1:0];
   assign comm_w = (rate_ff == '0) ? TIME_MAX :
                   (TIME_BITS'(startup_ff) + TIME_BITS'(quo_ff));
   assign asum_w = (TIME_BITS+1)'(fin_ff) + (TIME_BITS+1)'(comm_w);
   assign arr_w  = asum_w[TIME_BITS] ? TIME_MAX : asum_w[TIME_BITS-1:0];
   assign rshift_w = {rem_ff[DATA_BITS-1:0], quo_ff[DATA_BITS-1]};

   assign emit_fire = (state_ff == SC_EMIT) && out_free;
   assign ap_we  = emit_fire;
   assign tf_we  = emit_fire;
   assign last_w = (s_ff + 1'b1) == n_ff;

   hls_ram #(.WIDTH(COST_BITS), .DEPTH(CD)) u_cost (
      .clock(clock), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
      .raddr(cost_raddr), .rdata(cost_rdata));

   hls_ram #(.WIDTH(DATA_BITS), .DEPTH(RD)) u_rate (
      .clock(clock), .we(rate_we), .waddr(rate_waddr), .wdata(req_data.entry_value),
      .raddr(rate_raddr), .rdata(rate_rdata));

   hls_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_PROCS)) u_startup (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(req_data.entry_value),
      .raddr(st_raddr), .rdata(st_rdata));

   hls_ram #(.WIDTH(DATA_BITS+1), .DEPTH(ED)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .raddr(edge_raddr), .rdata(edge_rdata));

   hls_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_TASKS)) u_rank (
      .clock(clock), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
      .raddr(rank_raddr), .rdata(rank_rdata));

   hls_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_order (
      .clock(clock), .we(order_we), .waddr(order_waddr), .wdata(order_wdata),
      .raddr(order_raddr), .rdata(order_rdata));

   hls_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_assigned (
      .clock(clock), .we(ap_we), .waddr(t_ff), .wdata(bp_ff),
      .raddr(k_ff[TW-1:0]), .rdata(ap_rdata));

   hls_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_finish (
      .clock(clock), .we(tf_we), .waddr(t_ff), .wdata(bf_ff),
      .raddr(k_ff[TW-1:0]), .rdata(tf_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= 7'd2;
         proc_count_ff <= 4'd1;
         rsp_valid_ff  <= 1'b0;
         placed_ff     <= '0;
         for (int p = 0; p < MAX_PROCS; p++) begin
            pft_ff[p] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TASK_COUNT: task_count_ff <= csr_wdata;
               CSR_PROC_COUNT: proc_count_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_data.mode == MODE_START) && (n_w != '0)) begin
                  n_ff        <= n_w;
                  q_ff        <= q_w;
                  i_ff        <= n_w - 1'b1;
                  j_ff        <= '0;
                  cost_sum_ff <= '0;
                  best_ff     <= '0;
                  state_ff    <= RK_CRD;
               end
            end
            // upward ranks, last task first
            RK_CRD: state_ff <= RK_CACC;
            RK_CACC: begin
               cost_sum_ff <= cost_sum_ff + SW'(cost_rdata);
               j_ff        <= j_ff + 1'b1;
               state_ff    <= ((j_ff + 1'b1) == q_ff) ? RK_SINIT : RK_CRD;
            end
            RK_SINIT: begin
               k_ff     <= i_ff + 1'b1;
               state_ff <= ((i_ff + 1'b1) >= n_ff) ? RK_WR : RK_SRD;
            end
            RK_SRD: state_ff <= RK_SACC;
            RK_SACC: begin
               if (edge_rdata[DATA_BITS] && (v_w > best_ff)) begin
                  best_ff <= v_w;
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= ((k_ff + 1'b1) == n_ff) ? RK_WR : RK_SRD;
            end
            RK_WR: begin
               j_ff        <= '0;
               cost_sum_ff <= '0;
               best_ff     <= '0;
               if (i_ff == '0) begin
                  s_ff     <= '0;
                  pos_ff   <= '0;
                  t_ff     <= TW'(n_ff - 1'b1);
                  state_ff <= OR_TRK;
               end else begin
                  i_ff     <= i_ff - 1'b1;
                  state_ff <= RK_CRD;
               end
            end
            // insertion sort, descending rank
            OR_TRK: state_ff <= OR_TGET;
            OR_TGET: begin
               rank_t_ff <= rank_rdata;
               state_ff  <= OR_CHK;
            end
            OR_CHK: state_ff <= (pos_ff == '0) ? OR_PUT : OR_OGET;
            OR_OGET: begin
               prev_ff  <= order_rdata;
               state_ff <= OR_RRD;
            end
            OR_RRD: state_ff <= OR_CMP;
            OR_CMP: begin
               if (cmp_less) begin
                  pos_ff   <= pos_ff - 1'b1;
                  state_ff <= OR_CHK;
               end else begin
                  state_ff <= OR_PUT;
               end
            end
            OR_PUT: begin
               s_ff <= s_ff + 1'b1;
               if ((s_ff + 1'b1) == n_ff) begin
                  state_ff <= SC_INIT;
               end else begin
                  t_ff     <= t_ff - 1'b1;
                  pos_ff   <= s_ff + 1'b1;
                  state_ff <= OR_TRK;
               end
            end
            // placement
            SC_INIT: begin
               for (int p = 0; p < MAX_PROCS; p++) begin
                  pft_ff[p] <= '0;
               end
               placed_ff <= '0;
               s_ff      <= '0;
               state_ff  <= SC_ORD;
            end
            SC_ORD: state_ff <= SC_TGET;
            SC_TGET: begin
               t_ff     <= order_rdata;
               k_ff     <= '0;
               entry_ff <= 1'b1;
               state_ff <= SC_ERD;
            end
            SC_ERD: state_ff <= SC_EACC;
            SC_EACC: begin
               if (edge_rdata[DATA_BITS]) begin
                  entry_ff <= 1'b0;
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= ((k_ff + 1'b1) == n_ff) ? SC_BR : SC_ERD;
            end
            SC_BR: begin
               j_ff     <= '0;
               bs_ff    <= '0;
               state_ff <= entry_ff ? EN_RD : P_INIT;
            end
            EN_RD: state_ff <= EN_ACC;
            EN_ACC: begin
               if ((j_ff == '0) || (TIME_BITS'(cost_rdata) < bf_ff)) begin
                  bf_ff <= TIME_BITS'(cost_rdata);
                  bp_ff <= j_ff[PW-1:0];
               end
               j_ff     <= j_ff + 1'b1;
               state_ff <= ((j_ff + 1'b1) == q_ff) ? SC_EMIT : EN_RD;
            end
            P_INIT: begin
               est_ff   <= pft_ff[j_ff[PW-1:0]];
               k_ff     <= '0;
               state_ff <= P_ERD;
            end
            P_ERD: state_ff <= P_EGET;
            P_EGET: begin
               kp_ff   <= ap_rdata;
               fin_ff  <= tf_rdata;
               size_ff <= edge_rdata[DATA_BITS-1:0];
               if (edge_rdata[DATA_BITS] && placed_ff[k_ff[TW-1:0]]) begin
                  if (ap_rdata == j_ff[PW-1:0]) begin
                     // same processor, no transfer
                     if (tf_rdata > est_ff) begin
                        est_ff <= tf_rdata;
                     end
                     state_ff <= P_NEXT;
                  end else begin
                     state_ff <= P_RRD;
                  end
               end else begin
                  state_ff <= P_NEXT;
               end
            end
            P_RRD: state_ff <= P_RGET;
            P_RGET: begin
               rate_ff    <= rate_rdata;
               startup_ff <= st_rdata;
               rem_ff     <= '0;
               quo_ff     <= size_ff;
               div_cnt_ff <= '0;
               state_ff   <= (rate_rdata == '0) ? P_ARR : P_DIV;
            end
            // restoring divider, one quotient bit per cycle
            P_DIV: begin
               if (rshift_w >= {1'b0, rate_ff}) begin
                  rem_ff <= rshift_w - {1'b0, rate_ff};
                  quo_ff <= {quo_ff[DATA_BITS-2:0], 1'b1};
               end else begin
                  rem_ff <= rshift_w;
                  quo_ff <= {quo_ff[DATA_BITS-2:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 5'(DATA_BITS - 1)) begin
                  state_ff <= P_ARR;
               end
            end
            P_ARR: begin
               if (arr_w > est_ff) begin
                  est_ff <= arr_w;
               end
               state_ff <= P_NEXT;
            end
            P_NEXT: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= ((k_ff + 1'b1) == n_ff) ? P_CRD : P_ERD;
            end
            P_CRD: state_ff <= P_CACC;
            P_CACC: begin
               if ((j_ff == '0) || (fi_w < bf_ff)) begin
                  bp_ff <= j_ff[PW-1:0];
                  bs_ff <= est_ff;
                  bf_ff <= fi_w;
               end
               j_ff     <= j_ff + 1'b1;
               state_ff <= ((j_ff + 1'b1) == q_ff) ? SC_EMIT : P_INIT;
            end
            SC_EMIT: begin
               if (out_free) begin
                  placed_ff[t_ff] <= 1'b1;
                  pft_ff[bp_ff]   <= bf_ff;
                  rsp_data_ff.task_id          <= 6'(t_ff);
                  rsp_data_ff.chosen_processor <= 3'(bp_ff);
                  rsp_data_ff.start_time       <= bs_ff;
                  rsp_data_ff.finish_time      <= bf_ff;
                  rsp_data_ff.last             <= last_w;
                  s_ff     <= s_ff + 1'b1;
                  state_ff <= last_w ? ST_IDLE : SC_ORD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ design/hls_ram.sv @@
// ---------------------------------------------------------------------------
// hls_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire
